// ----- rtl/rmt_pkg.sv -----
// ----------------------------------------------------------------------------
// rmt_pkg - running median tracker shared definitions
// Field widths, the default store depth, the controller state type and the
// per-cell control bundle.
// ----------------------------------------------------------------------------
package rmt_pkg;

    // Item field widths
    localparam int SAMPLE_W = 32;
    localparam int MEDIAN_W = 33;
    localparam int COUNT_W  = 9;

    // Each cell drives a lower and an upper median candidate
    localparam int LEAF_W = 2 * SAMPLE_W;

    // Default number of cells in the sorted chain
    localparam int CAPACITY_DEF = 256;

    // Controller: wait for an item, let the select tree settle, hand off result
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FILL,
        ST_HOLD
    } rmt_state_t;

    // Control bundle fanned out to every cell
    typedef struct packed {
        logic ins_en;    // insert this item into the chain
        logic occupied;  // cell holds a sample
        logic sel_lo;    // cell sits at the lower middle position
        logic sel_hi;    // cell sits at the upper middle position
    } rmt_cell_ctl_t;

endpackage

// ----- rtl/running_median_tracker.sv -----
// ----------------------------------------------------------------------------
// running_median_tracker - running median of a signed sample stream
// Keeps up to CAPACITY samples in a sorted chain of cells and reports twice the
// median after every item.
// ----------------------------------------------------------------------------
// Input channel: sample with sample_valid / sample_stall. Output channel:
// median_doubled, sample_count, dropped with result_valid / result_stall.
// Every accepted item gives exactly one result item.
// An accepted sample is inserted into the sorted chain at the accepting edge;
// all cells shift in the same clock. The two middle cells then pass through a
// registered OR tree of L = clog2(CAPACITY) levels (8 at the default depth).
// The controller waits in ST_FILL while the value passes the tree levels, then
// loads the output register from ST_HOLD and raises result_valid; the next
// sample is taken only after that load, so the pace is set by the tree depth.
// The output register lets a new sample in while a result waits; while the
// receiver stalls, that result holds and the following one waits in the tree
// with sample_stall high. A full store drops the sample, sets dropped and
// repeats the last median. Reset clears the count and all handshake state;
// the cells need no clearing since only occupied cells are selected when a result is loaded.
// ----------------------------------------------------------------------------
module running_median_tracker
    import rmt_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       sample_valid,
    output logic                       sample_stall,
    input  logic signed [SAMPLE_W-1:0] sample,
    output logic                       result_valid,
    input  logic                       result_stall,
    output logic signed [MEDIAN_W-1:0] median_doubled,
    output logic [COUNT_W-1:0]         sample_count,
    output logic                       dropped
);

    localparam int CNTW     = $clog2(CAPACITY + 1);
    localparam int TREE_LAT = $clog2(CAPACITY);
    localparam int LATW     = $clog2(TREE_LAT + 1);

    rmt_state_t state_reg;
    rmt_state_t state_next;
    logic [LATW-1:0] lat_cnt_reg;
    logic [LATW-1:0] lat_cnt_next;
    logic [CNTW-1:0] count_reg;
    logic [CNTW-1:0] count_next;
    logic            drop_pend_reg;
    logic            result_valid_reg;
    logic            result_valid_next;
    logic signed [MEDIAN_W-1:0] median_reg;
    logic [COUNT_W-1:0]         count_out_reg;
    logic                       dropped_reg;

    logic            accept;
    logic            full;
    logic            load;
    logic [CNTW-1:0] lo_idx;
    logic [CNTW-1:0] hi_idx;
    logic [CNTW+COUNT_W-1:0] count_ext;

    logic signed [SAMPLE_W-1:0] cell_val [CAPACITY];
    logic                       cell_gt  [CAPACITY];
    logic [LEAF_W-1:0]          leaf     [CAPACITY];
    rmt_cell_ctl_t              cell_ctl [CAPACITY];
    logic [LEAF_W-1:0]          root;
    logic signed [SAMPLE_W-1:0] root_lo;
    logic signed [SAMPLE_W-1:0] root_hi;

    // Input handshake
    assign sample_stall = (state_reg != ST_IDLE);
    assign accept       = sample_valid && !sample_stall;
    assign full         = (count_reg == CNTW'(CAPACITY));

    // Middle positions: equal for an odd count, adjacent for an even one
    assign lo_idx = (count_reg - CNTW'(1)) >> 1;
    assign hi_idx = count_reg >> 1;

    // Sorted insertion chain
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic                       left_gt_w;
        logic signed [SAMPLE_W-1:0] left_val_w;

        assign cell_ctl[i].ins_en   = accept && !full;
        assign cell_ctl[i].occupied = (CNTW'(i) < count_reg);
        assign cell_ctl[i].sel_lo   = (CNTW'(i) == lo_idx);
        assign cell_ctl[i].sel_hi   = (CNTW'(i) == hi_idx);

        if (i == 0)
        begin : g_head
            assign left_gt_w  = 1'b0;
            assign left_val_w = '0;
        end
        else
        begin : g_link
            assign left_gt_w  = cell_gt[i-1];
            assign left_val_w = cell_val[i-1];
        end

        rmt_cell u_cell
        (
            .clk      (clk),
            .x        (sample),
            .ctl      (cell_ctl[i]),
            .left_gt  (left_gt_w),
            .left_val (left_val_w),
            .val      (cell_val[i]),
            .gt       (cell_gt[i]),
            .leaf     (leaf[i])
        );
    end

    // Pick the two middle values out of the chain
    rmt_or_tree #(
        .N_LEAVES (CAPACITY),
        .WIDTH    (LEAF_W)
    ) u_tree
    (
        .clk    (clk),
        .leaves (leaf),
        .root   (root)
    );

    assign root_lo = root[LEAF_W-1:SAMPLE_W];
    assign root_hi = root[SAMPLE_W-1:0];

    // Control state machine
    always_comb
    begin
        state_next   = state_reg;
        lat_cnt_next = lat_cnt_reg;
        load         = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next   = ST_FILL;
                    lat_cnt_next = LATW'(TREE_LAT);
                end
            end
            ST_FILL:
            begin
                lat_cnt_next = lat_cnt_reg - LATW'(1);
                if (lat_cnt_reg == LATW'(1))
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    load       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign count_next        = (accept && !full) ? count_reg + CNTW'(1) : count_reg;
    assign result_valid_next = load || (result_valid_reg && result_stall);
    assign count_ext         = (CNTW + COUNT_W)'(count_reg);

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            lat_cnt_reg      <= '0;
            count_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            lat_cnt_reg      <= lat_cnt_next;
            count_reg        <= count_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Item payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            drop_pend_reg <= full;
        end
        if (load)
        begin
            median_reg    <= MEDIAN_W'(root_lo) + MEDIAN_W'(root_hi);
            count_out_reg <= count_ext[COUNT_W-1:0];
            dropped_reg   <= drop_pend_reg;
        end
    end

    assign result_valid   = result_valid_reg;
    assign median_doubled = median_reg;
    assign sample_count   = count_out_reg;
    assign dropped        = dropped_reg;

`ifndef NO_ASSERTIONS
    // An accepted item always starts the tree wait
    a_accept_fill: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ST_FILL)
        else $error("accepted item did not start the select wait");

    // The count never passes the store depth
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNTW'(CAPACITY))
        else $error("held count above capacity");

    // The count grows by at most one per clock
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (count_reg == $past(count_reg)) ||
                 (count_reg == $past(count_reg) + CNTW'(1)))
        else $error("held count jumped");

    // A dropped sample means the store is and stays full
    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && dropped_reg |-> full)
        else $error("dropped result while store not full");

    // The selected middle values come out in order
    a_mid_order: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_HOLD |-> root_lo <= root_hi)
        else $error("middle values out of order");
`endif

endmodule

// ----- rtl/rmt_cell.sv -----
// ----------------------------------------------------------------------------
// rmt_cell - one slot of the sorted insertion chain
// Holds one sample. On insert it keeps its value, takes the new sample, or
// takes its left neighbor's value so the chain stays in ascending order.
// ----------------------------------------------------------------------------
module rmt_cell
    import rmt_pkg::*;
(
    input  logic                       clk,
    input  logic signed [SAMPLE_W-1:0] x,
    input  rmt_cell_ctl_t              ctl,
    input  logic                       left_gt,
    input  logic signed [SAMPLE_W-1:0] left_val,
    output logic signed [SAMPLE_W-1:0] val,
    output logic                       gt,
    output logic [LEAF_W-1:0]          leaf
);

    logic signed [SAMPLE_W-1:0] val_reg;
    logic signed [SAMPLE_W-1:0] val_next;

    // An empty cell counts as larger than any sample
    assign gt = !ctl.occupied || (val_reg > x);

    // Shift right where the left neighbor is larger, else drop in the sample where this cell is larger, else keep
    always_comb
    begin
        priority if (left_gt)
        begin
            val_next = left_val;
        end
        else if (gt)
        begin
            val_next = x;
        end
        else
        begin
            val_next = val_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.ins_en)
        begin
            val_reg <= val_next;
        end
    end

    assign val = val_reg;

    // Median candidates for the select tree
    assign leaf = {(ctl.sel_lo ? val_reg : {SAMPLE_W{1'b0}}),
                   (ctl.sel_hi ? val_reg : {SAMPLE_W{1'b0}})};

endmodule

// ----- rtl/rmt_or_tree.sv -----
// ----------------------------------------------------------------------------
// rmt_or_tree - registered OR reduction over the cell chain
// Binary tree with a register at every node; the root reflects the leaves
// through the node registers level by level. At most one leaf per bit lane is nonzero.
// ----------------------------------------------------------------------------
module rmt_or_tree
    import rmt_pkg::*;
#(
    parameter int N_LEAVES = CAPACITY_DEF,
    parameter int WIDTH    = LEAF_W
)
(
    input  logic             clk,
    input  logic [WIDTH-1:0] leaves [N_LEAVES],
    output logic [WIDTH-1:0] root
);

    localparam int LEVELS = $clog2(N_LEAVES);
    localparam int P      = 1 << LEVELS;

    logic [WIDTH-1:0] leaf_w   [P];
    logic [WIDTH-1:0] node_reg [P-1];

    // Pad the leaf row to a power of two
    for (genvar j = 0; j < P; j++)
    begin : g_leaf
        if (j < N_LEAVES)
        begin : g_real
            assign leaf_w[j] = leaves[j];
        end
        else
        begin : g_pad
            assign leaf_w[j] = '0;
        end
    end

    // Heap-ordered internal nodes, children at 2j+1 and 2j+2
    for (genvar j = 0; j < P - 1; j++)
    begin : g_node
        logic [WIDTH-1:0] left_w;
        logic [WIDTH-1:0] right_w;

        if (2 * j + 1 >= P - 1)
        begin : g_left_leaf
            assign left_w = leaf_w[2 * j + 1 - (P - 1)];
        end
        else
        begin : g_left_node
            assign left_w = node_reg[2 * j + 1];
        end

        if (2 * j + 2 >= P - 1)
        begin : g_right_leaf
            assign right_w = leaf_w[2 * j + 2 - (P - 1)];
        end
        else
        begin : g_right_node
            assign right_w = node_reg[2 * j + 2];
        end

        always_ff @(posedge clk)
        begin
            node_reg[j] <= left_w | right_w;
        end
    end

    assign root = node_reg[0];

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - running median tracker testbench
// Feeds a stream of signed samples through the valid/stall input channel and
// checks every result item against a sorted-list model of the tracker kept in
// the bench. A short table of directed samples comes first: field extremes,
// ties and the overflow corners of the doubled median. A long random stream
// follows and runs the store past full, so later samples must be dropped.
// Both channels idle in random bursts. The receiver also holds off once for a
// long stretch so that the block backs up and stalls its input.
// ----------------------------------------------------------------------------
module tb_top
    import rmt_pkg::*;
();

    localparam int STORE_DEPTH = CAPACITY_DEF;
    localparam int TOTAL_ITEMS = 1200;
    localparam int CALM_ITEMS  = 150;     // no idling on either side at the end
    localparam int HOLD_AT     = 120;     // item count that triggers the long hold
    localparam int LONG_HOLD   = 400;     // cycles of the long receiver hold-off
    localparam int DRAIN       = 32;      // settle time after the last result
    localparam int CYCLE_LIMIT = 200_000;
    localparam int DIR_N       = 22;

    // One result item as the block reports it
    typedef struct packed {
        logic signed [MEDIAN_W-1:0] median;
        logic [COUNT_W-1:0]         count;
        logic                       dropped;
    } median_res_t;

    // Directed stimulus row; known rows carry a hand-computed result
    typedef struct {
        logic signed [SAMPLE_W-1:0] smp;
        bit                         known;
        longint                     med;
        int                         cnt;
    } stim_row_t;

    stim_row_t dir_tab [DIR_N] = '{
        // single max sample: doubled median is the largest positive value
        '{32'sh7FFF_FFFF, 1'b1, 64'sd4294967294, 1},
        // max plus min: sum of the two middles is -1
        '{32'sh8000_0000, 1'b1, -64'sd1, 2},
        '{32'sh0000_0000, 1'b1, 64'sd0, 3},
        '{32'sh8000_0000, 1'b1, -64'sd2147483648, 4},
        // three minimums in the middle: most negative doubled median
        '{32'sh8000_0000, 1'b1, -64'sd4294967296, 5},
        // ties at the top, then mixed small values and bit patterns
        '{32'sh7FFF_FFFF, 1'b0, 64'sd0, 0},
        '{32'sh7FFF_FFFF, 1'b0, 64'sd0, 0},
        '{32'sh7FFF_FFFF, 1'b0, 64'sd0, 0},
        '{32'sh0000_0001, 1'b0, 64'sd0, 0},
        '{32'shFFFF_FFFF, 1'b0, 64'sd0, 0},
        '{32'sh0000_0001, 1'b0, 64'sd0, 0},
        '{32'sh0000_0001, 1'b0, 64'sd0, 0},
        '{32'sh5555_5555, 1'b0, 64'sd0, 0},
        '{32'shAAAA_AAAA, 1'b0, 64'sd0, 0},
        '{32'sh0000_FFFF, 1'b0, 64'sd0, 0},
        '{32'shFFFF_0000, 1'b0, 64'sd0, 0},
        '{32'shFFFF_FFFE, 1'b0, 64'sd0, 0},
        '{32'sh0000_0002, 1'b0, 64'sd0, 0},
        '{32'sh0000_0000, 1'b0, 64'sd0, 0},
        '{32'sh0000_0000, 1'b0, 64'sd0, 0},
        '{32'sh0000_0040, 1'b0, 64'sd0, 0},
        '{32'shFFFF_FF9C, 1'b0, 64'sd0, 0}
    };

    logic                       clk;
    logic                       rst_n;
    logic                       sample_valid;
    logic                       sample_stall;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       result_valid;
    logic                       result_stall;
    logic signed [MEDIAN_W-1:0] median_doubled;
    logic [COUNT_W-1:0]         sample_count;
    logic                       dropped;

    // Bench copy of the held samples, ascending
    logic signed [SAMPLE_W-1:0] sorted_hold [$];
    median_res_t                median_due_q [$];

    int  items_sent    = 0;
    int  results_seen  = 0;
    int  drops_seen    = 0;
    int  err_cnt       = 0;
    int  cyc_cnt       = 0;
    bit  idle_ok       = 1'b0;
    bit  held_long     = 1'b0;

    running_median_tracker #(
        .CAPACITY       (STORE_DEPTH)
    ) u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .sample_valid   (sample_valid),
        .sample_stall   (sample_stall),
        .sample         (sample),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .median_doubled (median_doubled),
        .sample_count   (sample_count),
        .dropped        (dropped)
    );

    // Clock
    initial
    begin : clock_gen
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Insert a sample into the sorted copy and work out the reported result
    function automatic median_res_t track_sample(logic signed [SAMPLE_W-1:0] x);
        median_res_t r;
        int          pos;
        int          n;
        longint      dbl;
        r.dropped = (sorted_hold.size() >= STORE_DEPTH);
        if (!r.dropped)
        begin
            pos = sorted_hold.size();
            while (pos > 0 && sorted_hold[pos-1] > x)
                pos--;
            sorted_hold.insert(pos, x);
        end
        n = sorted_hold.size();
        if (n == 0)
            dbl = 0;
        else if (n % 2 == 1)
            dbl = 2 * longint'(sorted_hold[n/2]);
        else
            dbl = longint'(sorted_hold[n/2-1]) + longint'(sorted_hold[n/2]);
        r.median = dbl[MEDIAN_W-1:0];
        r.count  = n[COUNT_W-1:0];
        return r;
    endfunction

    // Random sample: full range, tight clusters for ties, extremes, bit walks
    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        logic signed [SAMPLE_W-1:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = $urandom;
            4, 5:
            begin
                v = $urandom_range(0, 16);
                v = v - 8;
            end
            6:
            begin
                if ($urandom_range(0, 1) == 1)
                    v = 32'sh7FFF_FFFF - $urandom_range(0, 3);
                else
                    v = 32'sh8000_0000 + $urandom_range(0, 3);
            end
            7:
            begin
                v = 32'sh1 << $urandom_range(0, 31);
                if ($urandom_range(0, 1) == 1)
                    v = ~v;
            end
            default:
            begin
                v = $urandom_range(0, 2000);
                v = v - 1000;
            end
        endcase
        return v;
    endfunction

    // Offer one item, wait for it to be taken, then queue its expected result
    task automatic offer_sample(input logic signed [SAMPLE_W-1:0] smp, input bit known,
                                input median_res_t typed_res);
        median_res_t want;
        int          gap;
        if (idle_ok && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 13);
            sample_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample       <= smp;
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
        want = track_sample(smp);
        if (known)
            want = typed_res;
        median_due_q.push_back(want);
        items_sent++;
    endtask

    // Failure reporting: first ten in full, the rest only counted
    task automatic note_error(input string msg);
        err_cnt++;
        if (err_cnt <= 10)
            $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    // Result side: random stall bursts plus one long hold-off
    initial
    begin : result_side
        int gap;
        result_stall <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (!held_long && items_sent >= HOLD_AT)
            begin
                held_long = 1'b1;
                result_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                result_stall <= 1'b0;
            end
            else if (idle_ok && $urandom_range(0, 5) == 0)
            begin
                gap = $urandom_range(1, 13);
                result_stall <= 1'b1;
                repeat (gap) @(posedge clk);
                result_stall <= 1'b0;
            end
        end
    end

    // Compare each taken result with the oldest expectation
    always @(posedge clk)
    begin : result_check
        median_res_t got;
        median_res_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            got.median  = median_doubled;
            got.count   = sample_count;
            got.dropped = dropped;
            results_seen++;
            if (got.dropped)
                drops_seen++;
            if (median_due_q.size() == 0)
            begin
                note_error($sformatf("result with none expected: med=%0d cnt=%0d drop=%0b",
                                     got.median, got.count, got.dropped));
            end
            else
            begin
                want = median_due_q.pop_front();
                if (got.median !== want.median || got.count !== want.count
                    || got.dropped !== want.dropped)
                    note_error($sformatf({"result %0d: exp med=%0d cnt=%0d drop=%0b, ",
                                          "got med=%0d cnt=%0d drop=%0b"},
                                         results_seen, want.median, want.count,
                                         want.dropped, got.median, got.count,
                                         got.dropped));
            end
        end
    end

    // Watchdog
    always @(posedge clk)
        cyc_cnt <= cyc_cnt + 1;

    initial
    begin : watchdog
        wait (cyc_cnt >= CYCLE_LIMIT);
        $display("Timeout after %0d cycles, %0d results still due", cyc_cnt,
                 median_due_q.size());
        $display("CHECK FAILED");
        $finish;
    end

    // Stimulus: reset, directed table, random stream, drain
    initial
    begin : stimulus
        median_res_t typed_res;
        rst_n        <= 1'b0;
        sample_valid <= 1'b0;
        sample       <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_N; i++)
        begin
            idle_ok = (i % 8) < 5;
            typed_res.median  = dir_tab[i].med[MEDIAN_W-1:0];
            typed_res.count   = dir_tab[i].cnt[COUNT_W-1:0];
            typed_res.dropped = 1'b0;
            offer_sample(dir_tab[i].smp, dir_tab[i].known, typed_res);
        end

        // idle-free windows every fourth hundred items and at the very end
        for (int i = DIR_N; i < TOTAL_ITEMS; i++)
        begin
            idle_ok = (i < TOTAL_ITEMS - CALM_ITEMS) && ((i / 100) % 4 != 3);
            offer_sample(pick_sample(), 1'b0, typed_res);
        end
        sample_valid <= 1'b0;
        idle_ok = 1'b0;

        while (median_due_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);

        $display("Run: %0d samples (%0d directed), %0d results checked, %0d dropped at full store",
                 items_sent, DIR_N, results_seen, drops_seen);
        $display("Receiver long hold-off of %0d cycles %0s; %0d failures",
                 LONG_HOLD, held_long ? "applied" : "not reached", err_cnt);
        if (err_cnt == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
